// ===== hdl/mcrc_pkg.sv =====
package mcrc_pkg;

    // Frame layout
    localparam int PAYLOAD_BYTES = 62;
    localparam int POS_W         = 8;
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(PAYLOAD_BYTES);
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(PAYLOAD_BYTES + 1);

    // CRC-16/MODBUS constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // One incoming byte with its start flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_byte_item;

    // One frame verdict
    typedef struct packed {
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
        logic        crc_match;
    } t_result;

    // Reflected CRC update over one byte, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/mcrc_in_stage.sv =====
module mcrc_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  mcrc_pkg::t_byte_item i_item,
    input  logic                i_consume,
    output logic                o_valid,
    output mcrc_pkg::t_byte_item o_item
);
    import mcrc_pkg::*;

    logic       r_valid;
    logic       n_valid;
    t_byte_item r_item;

    // Take a new transaction when empty or when the held one moves on
    assign o_ready = !r_valid || i_consume;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_consume) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload holds without reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== hdl/mcrc_frame_core.sv =====
module mcrc_frame_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  mcrc_pkg::t_byte_item i_item,
    input  logic                 i_out_free,
    output logic                 o_consume,
    output logic                 o_res_valid,
    output mcrc_pkg::t_result    o_res
);
    import mcrc_pkg::*;

    logic [15:0]      r_crc;
    logic [15:0]      n_crc;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_crc_lo;
    logic [7:0]       n_crc_lo;

    logic [15:0]      crc_eff;
    logic [POS_W-1:0] pos_eff;
    logic             is_end;
    logic [15:0]      rx_crc;

    // Restart on the start flag before using the byte
    assign crc_eff = i_item.frame_start ? CRC_INIT : r_crc;
    assign pos_eff = i_item.frame_start ? '0 : r_pos;
    assign is_end  = (pos_eff == POS_CRC_HI);

    // A frame end needs room in the result register
    assign o_consume   = i_valid && (!is_end || i_out_free);
    assign o_res_valid = o_consume && is_end;

    assign rx_crc              = {i_item.data_byte, r_crc_lo};
    assign o_res.computed_crc  = crc_eff;
    assign o_res.received_crc  = rx_crc;
    assign o_res.crc_match     = (crc_eff == rx_crc);

    // Advance frame state
    always_comb begin
        n_crc    = r_crc;
        n_pos    = r_pos;
        n_crc_lo = r_crc_lo;
        if (o_consume) begin
            if (pos_eff < POS_CRC_LO) begin
                n_crc = crc_byte(crc_eff, i_item.data_byte);
                n_pos = pos_eff + 1'b1;
            end else if (pos_eff == POS_CRC_LO) begin
                n_crc    = crc_eff;
                n_crc_lo = i_item.data_byte;
                n_pos    = pos_eff + 1'b1;
            end else begin
                n_crc = CRC_INIT;
                n_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CRC_INIT;
            r_pos    <= '0;
            r_crc_lo <= '0;
        end else begin
            r_crc    <= n_crc;
            r_pos    <= n_pos;
            r_crc_lo <= n_crc_lo;
        end
    end
endmodule

// ===== hdl/mcrc_out_stage.sv =====
module mcrc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mcrc_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output mcrc_pkg::t_result o_res
);
    import mcrc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Room when empty or when the held transaction leaves now
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ===== hdl/modbus_crc_frame_checker_unit.sv =====
// Checks CRC-16/MODBUS on fixed frames of PAYLOAD_BYTES payload bytes followed by a
// little-endian two-byte checksum. One byte is taken per cycle with no gaps needed unless
// a frame end waits for room in the result register; a byte passes an input register and
// the combinational byte CRC update, and each verdict lands in a result register.
// Only the last byte of each frame yields a result transaction; a set start flag
// drops any unfinished frame and begins a new one, and frames may also run back to
// back without it. Input ready drops only while a frame end waits on a result held downstream.
module modbus_crc_frame_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_computed_crc,
    output logic [15:0] o_received_crc,
    output logic        o_crc_match
);
    import mcrc_pkg::*;

    t_byte_item in_item;
    t_byte_item held_item;
    logic       held_valid;
    logic       consume;
    logic       out_free;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign in_item.data_byte   = i_data_byte;
    assign in_item.frame_start = i_frame_start;

    mcrc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_consume (consume),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    mcrc_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .i_item      (held_item),
        .i_out_free  (out_free),
        .o_consume   (consume),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mcrc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (i_ready),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_computed_crc = out_res.computed_crc;
    assign o_received_crc = out_res.received_crc;
    assign o_crc_match    = out_res.crc_match;
endmodule

// ===== hdl/mcrc_checker.sv =====
module mcrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_computed_crc,
    input logic [15:0] o_received_crc,
    input logic        o_crc_match
);
    // Match flag agrees with the two checksums
    a_match_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_crc_match == (o_computed_crc == o_received_crc)))
        else $error("crc_match disagrees with checksums");

    // Reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_computed_crc)
            && $stable(o_received_crc) && $stable(o_crc_match)))
        else $error("stalled result changed");

    // Input side never stalls while the result side is free
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && $past(!o_valid)) |-> o_ready)
        else $error("input stalled with empty result register");
endmodule

bind modbus_crc_frame_checker_unit mcrc_checker u_mcrc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_computed_crc (o_computed_crc),
    .o_received_crc (o_received_crc),
    .o_crc_match    (o_crc_match)
);
